// ----- src/sliding_window_frame_detector_top_assert.svh -----
// Assertion macros shared by the frame detector RTL.
`ifndef SLIDING_WINDOW_FRAME_DETECTOR_TOP_ASSERT_SVH
`define SLIDING_WINDOW_FRAME_DETECTOR_TOP_ASSERT_SVH

// Generic clocked assertion, disabled while reset is asserted.
`define SWFD_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the default clock and reset of the design.
`define SWFD_ASSERT(label, prop, msg) \
  `SWFD_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- src/swfd_pkg.sv -----
// Shared types and constants of the sliding window frame detector.
package swfd_pkg;

  localparam int unsigned FRAME_LEN_DEF = 8;
  localparam int unsigned BYTE_W        = 8;

  // Register select, taken from paddr bit 2.
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_ID     = 1'b1;

  // Control shared by every cell of the chain.
  typedef struct packed {
    logic shift_win;  // window moves one place toward the oldest end
    logic load_out;   // output chain takes a copy of the window
    logic shift_out;  // output chain moves one place toward the head
  } cell_ctrl_t;

endpackage

// ----- src/sliding_window_frame_detector_top.sv -----
// Top level of the sliding window frame detector.
//
// Input channel: one rx byte per beat (in_valid_i / in_stall_o). Each byte is
// shifted into a FRAME_LEN byte window held in a chain of cells. The window
// is a frame when its oldest byte equals the header register, the next one
// equals the id register, and the newest byte equals the 8-bit sum of all
// the others.
// Output channel: on a frame, FRAME_LEN beats of frame_byte_o, oldest first,
// with frame_last_o high on the checksum byte (out_valid_o / out_stall_i).
// Order: a byte is accepted in ST_IDLE, then tested in ST_CHECK, after which
// a byte that completes no frame returns to ST_IDLE. A matching byte adds
// FRAME_LEN output beats, one per cycle when the receiver does not stall; the
// first beat is loaded in ST_CHECK and valid in ST_EMIT until it is taken.
// The window test uses a running sum register, so its cost does not grow.
// in_stall_o stays high while a byte is tested or a frame is emitted. When
// the receiver stalls, the current beat holds until it is taken.
// Reset clears the window, the running sum and both registers; after reset
// the block is ready at once. Registers: header at 0x0, id at 0x4.
module sliding_window_frame_detector_top #(
  parameter int unsigned FRAME_LEN = swfd_pkg::FRAME_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [swfd_pkg::BYTE_W-1:0]   rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [swfd_pkg::BYTE_W-1:0]   frame_byte_o,
  output logic                          frame_last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  `include "sliding_window_frame_detector_top_assert.svh"

  localparam int unsigned BW   = swfd_pkg::BYTE_W;
  localparam int unsigned CntW = $clog2(FRAME_LEN);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [BW-1:0]       sum_q, sum_d;
  logic [BW-1:0]       hdr_q, id_q;
  logic                in_acc, out_acc, cfg_wr, match;
  swfd_pkg::cell_ctrl_t ctrl;

  logic [BW-1:0] win  [FRAME_LEN];
  logic [BW-1:0] outb [FRAME_LEN];

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= '0;
      id_q  <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == swfd_pkg::REG_HEADER) begin
        hdr_q <= pwdata[BW-1:0];
      end else begin
        id_q <= pwdata[BW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == swfd_pkg::REG_ID) begin
      prdata = {{(32-BW){1'b0}}, id_q};
    end else begin
      prdata = {{(32-BW){1'b0}}, hdr_q};
    end
  end

  // ---------------- cell chain ----------------
  for (genvar k = 0; k < FRAME_LEN; k++) begin : g_cell
    logic [BW-1:0] win_next, out_next;
    if (k == FRAME_LEN - 1) begin : g_tail
      assign win_next = rx_byte_i;
      assign out_next = '0;
    end else begin : g_body
      assign win_next = win[k+1];
      assign out_next = outb[k+1];
    end
    swfd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .win_next_i (win_next),
      .out_next_i (out_next),
      .win_o      (win[k]),
      .out_o      (outb[k])
    );
  end

  // ---------------- control ----------------
  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = (state_q == ST_EMIT);
  assign in_acc       = in_valid_i & ~in_stall_o;
  assign out_acc      = out_valid_o & ~out_stall_i;
  assign frame_byte_o = outb[0];
  assign frame_last_o = (cnt_q == '0);

  // sum_q tracks the sum of every window byte but the newest one
  assign match = (win[0] == hdr_q) && (win[1] == id_q) && (sum_q == win[FRAME_LEN-1]);

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    sum_d          = sum_q;
    ctrl.shift_win = 1'b0;
    ctrl.load_out  = 1'b0;
    ctrl.shift_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ctrl.shift_win = 1'b1;
          sum_d          = sum_q - win[0] + win[FRAME_LEN-1];
          state_d        = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (match) begin
          ctrl.load_out = 1'b1;
          cnt_d         = CntW'(FRAME_LEN - 1);
          state_d       = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (cnt_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            ctrl.shift_out = 1'b1;
            cnt_d          = cnt_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

  // ---------------- assertions ----------------
  `SWFD_ASSERT(a_no_in_during_emit, out_valid_o |-> in_stall_o,
               "input accepted while a frame is emitted")
  `SWFD_ASSERT(a_match_starts_frame,
               (state_q == ST_CHECK) && match |=> out_valid_o && (frame_byte_o == hdr_q),
               "matching window did not start a frame with the header byte")
  `SWFD_ASSERT(a_last_ends_frame, out_acc && frame_last_o |=> !out_valid_o && !in_stall_o,
               "frame did not end after its last beat")
  `SWFD_ASSERT(a_accept_then_check, in_acc |=> in_stall_o && !out_valid_o,
               "accepted byte was not tested before output")

endmodule

// ----- src/swfd_cell.sv -----
// One window cell: a window byte and an output byte, both chained to the neighbor.
module swfd_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  swfd_pkg::cell_ctrl_t                ctrl_i,
  input  logic [swfd_pkg::BYTE_W-1:0]         win_next_i,
  input  logic [swfd_pkg::BYTE_W-1:0]         out_next_i,
  output logic [swfd_pkg::BYTE_W-1:0]         win_o,
  output logic [swfd_pkg::BYTE_W-1:0]         out_o
);

  logic [swfd_pkg::BYTE_W-1:0] win_q, win_d;
  logic [swfd_pkg::BYTE_W-1:0] out_q, out_d;

  always_comb begin
    win_d = win_q;
    if (ctrl_i.shift_win) begin
      win_d = win_next_i;
    end
  end

  always_comb begin
    out_d = out_q;
    if (ctrl_i.load_out) begin
      out_d = win_q;
    end else if (ctrl_i.shift_out) begin
      out_d = out_next_i;
    end
  end

  // Window is architectural state and clears at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign win_o = win_q;
  assign out_o = out_q;

endmodule
